// ===== rtl/bmc_pkg.sv =====
// ----------------------------------------------------------------------------
// bmc_pkg: shared types and constants for the mask centroid block
// Field widths, frame limits and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package bmc_pkg;

  localparam int PIX_W = 8;
  localparam int COORD_W = 12;
  localparam int SUM_W = 36;
  localparam int HIT_W = 25;
  localparam int CENTER_W = 20;

  localparam logic [PIX_W-1:0] MASK_ON_VALUE = 8'd255;

  // frame limits, 17 bits so that 65536 fits
  localparam logic [16:0] MAX_COLS = 17'd4096;
  localparam logic [16:0] MAX_ROWS = 17'd4096;

  localparam logic [HIT_W-1:0] HIT_MAX = {HIT_W{1'b1}};

  typedef struct packed {
    logic acc_en;    // pixel transfer, accumulate
    logic start;     // frame end: load divider, clear sums
    logic step;      // one divider iteration
    logic load_out;  // move quotients into the output register
  } bmc_cmd_t;

  typedef struct packed {
    logic empty_next;  // count after this pixel is zero
    logic div_done;    // current step is the final one
  } bmc_stat_t;

endpackage

`default_nettype wire

// ===== rtl/binary_mask_centroid.sv =====
// ----------------------------------------------------------------------------
// binary_mask_centroid: centroid of the set pixels of a binary mask frame
// Accumulates column and row sums of pixels equal to 255, divides at frame end.
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// s_*      in   s_tvalid / s_tready  s_tdata: pixel_value, col, row; s_tlast: last_pixel
// m_*      out  m_tvalid / m_tready  m_tdata: center_x, center_y; m_tuser: empty_res
//
// Pixels take one cycle each. After the last pixel of a frame s_tready drops
// while the shared-counter bit-serial dividers run (they are skipped for
// an empty frame) and until the output register is loaded; that register
// may still hold the previous result, and loading waits on m_tready.
// Synchronous active-high reset clears the sums, the controller and m_tvalid.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_mask_centroid #(
  parameter int FRAC_BITS = 8
) (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        s_tvalid,
  output logic              s_tready,
  input  wire  logic [31:0] s_tdata,   // [7:0] pixel_value, [19:8] col, [31:20] row
  input  wire  logic        s_tlast,   // last_pixel
  output logic              m_tvalid,
  input  wire  logic        m_tready,
  output logic [39:0]       m_tdata,   // [19:0] center_x, [39:20] center_y
  output logic              m_tuser    // empty_res
);

  bmc_pkg::bmc_cmd_t  cmd;
  bmc_pkg::bmc_stat_t stat;
  logic [bmc_pkg::CENTER_W-1:0] center_x;
  logic [bmc_pkg::CENTER_W-1:0] center_y;

  bmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bmc_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .pixel_value (s_tdata[7:0]),
    .col         (s_tdata[19:8]),
    .row         (s_tdata[31:20]),
    .stat        (stat),
    .center_x    (center_x),
    .center_y    (center_y),
    .empty_res   (m_tuser)
  );

  assign m_tdata = {center_y, center_x};

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("empty result with nonzero centers");

  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> !s_tready)
    else $error("input accepted right after frame end");

  a_step_no_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !s_tready)
    else $error("input ready while dividing");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> m_tvalid)
    else $error("output load without valid");

endmodule

`default_nettype wire

// ===== rtl/bmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmc_ctrl: sequencing for the mask centroid block
// Accumulate phase, divider phase and output hand-off, plus output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module bmc_ctrl (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire                logic s_tvalid,
  input  wire                logic s_tlast,
  output logic               s_tready,
  output logic               m_tvalid,
  input  wire                logic m_tready,
  input  wire bmc_pkg::bmc_stat_t stat,
  output bmc_pkg::bmc_cmd_t  cmd
);

  localparam logic [1:0] ST_ACC = 2'd0;
  localparam logic [1:0] ST_DIV = 2'd1;
  localparam logic [1:0] ST_OUT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid;
  logic       out_valid_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    s_tready = 1'b0;
    case (state)
      ST_ACC: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.acc_en = 1'b1;
          if (s_tlast) begin
            cmd.start = 1'b1;
            // empty frame: quotient register is already zero
            state_next = stat.empty_next ? ST_OUT : ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (stat.div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next = ST_ACC;
        end
      end
      default: begin
        state_next = ST_ACC;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACC;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign m_tvalid = out_valid;

endmodule

`default_nettype wire

// ===== rtl/bmc_dp.sv =====
// ----------------------------------------------------------------------------
// bmc_dp: datapath for the mask centroid block
// Sum and count accumulators, two restoring divider lanes, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bmc_dp #(
  parameter int FRAC_BITS = 8
) (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire bmc_pkg::bmc_cmd_t cmd,
  input  wire                logic [bmc_pkg::PIX_W-1:0] pixel_value,
  input  wire                logic [bmc_pkg::COORD_W-1:0] col,
  input  wire                logic [bmc_pkg::COORD_W-1:0] row,
  output bmc_pkg::bmc_stat_t stat,
  output logic [bmc_pkg::CENTER_W-1:0] center_x,
  output logic [bmc_pkg::CENTER_W-1:0] center_y,
  output logic               empty_res
);

  localparam int SUM_W = bmc_pkg::SUM_W;
  localparam int HIT_W = bmc_pkg::HIT_W;
  localparam int OUT_W = bmc_pkg::CENTER_W;
  localparam int DVD_W = SUM_W + FRAC_BITS;
  localparam int CNT_W = $clog2(DVD_W);

  logic [SUM_W-1:0] sum_x;
  logic [SUM_W-1:0] sum_y;
  logic [HIT_W-1:0] hit_count;
  logic [SUM_W-1:0] sum_x_next;
  logic [SUM_W-1:0] sum_y_next;
  logic [HIT_W-1:0] hit_count_next;
  logic [SUM_W:0]   sx_ext;
  logic [SUM_W:0]   sy_ext;
  logic             hit;

  logic [DVD_W-1:0] dvd_x;
  logic [DVD_W-1:0] dvd_y;
  logic [HIT_W-1:0] rem_x;
  logic [HIT_W-1:0] rem_y;
  logic [HIT_W-1:0] divisor;
  logic [CNT_W-1:0] step_cnt;
  logic             empty_flag;

  logic [HIT_W:0]   shx;
  logic [HIT_W:0]   shy;
  logic [HIT_W:0]   diffx;
  logic [HIT_W:0]   diffy;
  logic             gex;
  logic             gey;

  always_comb begin
    sx_ext = {1'b0, sum_x} + {{(SUM_W + 1 - bmc_pkg::COORD_W){1'b0}}, col};
    sy_ext = {1'b0, sum_y} + {{(SUM_W + 1 - bmc_pkg::COORD_W){1'b0}}, row};
    hit = (pixel_value == bmc_pkg::MASK_ON_VALUE)
        && ({5'b0, col} < bmc_pkg::MAX_COLS)
        && ({5'b0, row} < bmc_pkg::MAX_ROWS)
        && (hit_count != bmc_pkg::HIT_MAX)
        && !sx_ext[SUM_W] && !sy_ext[SUM_W];
    sum_x_next = sum_x;
    sum_y_next = sum_y;
    hit_count_next = hit_count;
    if (cmd.acc_en && hit) begin
      sum_x_next = sx_ext[SUM_W-1:0];
      sum_y_next = sy_ext[SUM_W-1:0];
      hit_count_next = hit_count + 1'b1;
    end
    stat.empty_next = (hit_count_next == '0);
    stat.div_done = (step_cnt == '0);
  end

  // restoring division step, one quotient bit per lane per cycle
  always_comb begin
    shx = {rem_x, dvd_x[DVD_W-1]};
    shy = {rem_y, dvd_y[DVD_W-1]};
    gex = (shx >= {1'b0, divisor});
    gey = (shy >= {1'b0, divisor});
    diffx = shx - {1'b0, divisor};
    diffy = shy - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x <= '0;
      sum_y <= '0;
      hit_count <= '0;
    end else if (cmd.start) begin
      sum_x <= '0;
      sum_y <= '0;
      hit_count <= '0;
    end else begin
      sum_x <= sum_x_next;
      sum_y <= sum_y_next;
      hit_count <= hit_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dvd_x <= DVD_W'(sum_x_next) << FRAC_BITS;
      dvd_y <= DVD_W'(sum_y_next) << FRAC_BITS;
      rem_x <= '0;
      rem_y <= '0;
      divisor <= hit_count_next;
      step_cnt <= CNT_W'(DVD_W - 1);
      empty_flag <= stat.empty_next;
    end else if (cmd.step) begin
      dvd_x <= {dvd_x[DVD_W-2:0], gex};
      dvd_y <= {dvd_y[DVD_W-2:0], gey};
      rem_x <= gex ? diffx[HIT_W-1:0] : shx[HIT_W-1:0];
      rem_y <= gey ? diffy[HIT_W-1:0] : shy[HIT_W-1:0];
      step_cnt <= step_cnt - 1'b1;
    end
  end

  // saturate quotients that do not fit the output field
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      center_x <= (|dvd_x[DVD_W-1:OUT_W]) ? {OUT_W{1'b1}} : dvd_x[OUT_W-1:0];
      center_y <= (|dvd_y[DVD_W-1:OUT_W]) ? {OUT_W{1'b1}} : dvd_y[OUT_W-1:0];
      empty_res <= empty_flag;
    end
  end

endmodule

`default_nettype wire

// ===== verif/bmc_centroid_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmc_centroid_checker: result checker for the mask centroid block
// Watches the pixel and result streams. It keeps its own column and row sums
// and a hit count, and queues the expected centroid at each frame end. Each
// result transfer is compared field by field with the oldest queued entry.
// ----------------------------------------------------------------------------

module bmc_centroid_checker #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // [7:0] pixel_value, [19:8] col, [31:20] row
  input  logic        s_tlast,   // last_pixel
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // [19:0] center_x, [39:20] center_y
  input  logic        m_tuser,   // empty_res
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [bmc_pkg::CENTER_W-1:0] center_x;
    logic [bmc_pkg::CENTER_W-1:0] center_y;
    logic                         empty;
  } centroid_t;

  logic [bmc_pkg::SUM_W-1:0] sum_x;
  logic [bmc_pkg::SUM_W-1:0] sum_y;
  logic [bmc_pkg::HIT_W-1:0] hit_count;
  centroid_t                 centroid_q[$];

  // floor((sum << FRAC_BITS) / count), saturated to the output width
  function automatic logic [bmc_pkg::CENTER_W-1:0] fixed_mean(
      input logic [bmc_pkg::SUM_W-1:0] sum,
      input logic [bmc_pkg::HIT_W-1:0] count);
    logic [63:0] quot;
    quot = ({28'd0, sum} << FRAC_BITS) / {39'd0, count};
    if (quot > {44'd0, {bmc_pkg::CENTER_W{1'b1}}})
      return {bmc_pkg::CENTER_W{1'b1}};
    return quot[bmc_pkg::CENTER_W-1:0];
  endfunction

  task automatic clear_sums();
    sum_x = '0;
    sum_y = '0;
    hit_count = '0;
  endtask

  task automatic accumulate_pixel(input logic [31:0] data, input logic last);
    logic [bmc_pkg::PIX_W-1:0]   value;
    logic [bmc_pkg::COORD_W-1:0] col;
    logic [bmc_pkg::COORD_W-1:0] row;
    logic [bmc_pkg::SUM_W:0]     next_x;
    logic [bmc_pkg::SUM_W:0]     next_y;
    centroid_t                   centroid;
    value = data[7:0];
    col = data[19:8];
    row = data[31:20];
    next_x = {1'b0, sum_x} + {{(bmc_pkg::SUM_W + 1 - bmc_pkg::COORD_W){1'b0}}, col};
    next_y = {1'b0, sum_y} + {{(bmc_pkg::SUM_W + 1 - bmc_pkg::COORD_W){1'b0}}, row};
    // off-frame pixels and a full accumulator leave the sums as they are
    if (value == bmc_pkg::MASK_ON_VALUE
        && {5'd0, col} < bmc_pkg::MAX_COLS && {5'd0, row} < bmc_pkg::MAX_ROWS
        && hit_count < bmc_pkg::HIT_MAX
        && !next_x[bmc_pkg::SUM_W] && !next_y[bmc_pkg::SUM_W]) begin
      sum_x = next_x[bmc_pkg::SUM_W-1:0];
      sum_y = next_y[bmc_pkg::SUM_W-1:0];
      hit_count = hit_count + 1'b1;
    end
    if (last) begin
      if (hit_count == '0) begin
        centroid.center_x = '0;
        centroid.center_y = '0;
        centroid.empty = 1'b1;
      end else begin
        centroid.center_x = fixed_mean(sum_x, hit_count);
        centroid.center_y = fixed_mean(sum_y, hit_count);
        centroid.empty = 1'b0;
      end
      centroid_q.insert(centroid_q.size(), centroid);
      clear_sums();
    end
  endtask

  task automatic compare_centroid(input logic [39:0] data, input logic empty);
    centroid_t exp_c;
    if (centroid_q.size() == 0) begin
      mismatches++;
      $display("%0t: result with none expected: center_x=%h center_y=%h empty=%b",
               $time, data[19:0], data[39:20], empty);
    end else begin
      exp_c = centroid_q.pop_front();
      if (data[19:0] !== exp_c.center_x) begin
        mismatches++;
        $display("%0t: center_x expected %h actual %h", $time, exp_c.center_x, data[19:0]);
      end
      if (data[39:20] !== exp_c.center_y) begin
        mismatches++;
        $display("%0t: center_y expected %h actual %h", $time, exp_c.center_y, data[39:20]);
      end
      if (empty !== exp_c.empty) begin
        mismatches++;
        $display("%0t: empty_res expected %b actual %b", $time, exp_c.empty, empty);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_sums();
      centroid_q.delete();
    end else begin
      if (m_tvalid && m_tready)
        compare_centroid(m_tdata, m_tuser);
      if (s_tvalid && s_tready)
        accumulate_pixel(s_tdata, s_tlast);
    end
    outstanding = centroid_q.size();
  end

endmodule

// ===== verif/binary_mask_centroid_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_mask_centroid_tb: testbench top for the mask centroid block
// Streams directed and random mask frames into the block under three flow
// control mixes, lets the checker score every result and prints the verdict.
// ----------------------------------------------------------------------------

module binary_mask_centroid_tb;

  localparam int RANDOM_PIXELS = 2000;
  localparam int STALL_LIMIT   = 5000;  // cycles with no transfer on either side
  localparam int TAIL_CYCLES   = 100;   // divider plus output load, with margin

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [7:0] pixel_value, [19:8] col, [31:20] row
  logic        s_tlast;   // last_pixel
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // [19:0] center_x, [39:20] center_y
  logic        m_tuser;   // empty_res

  int mismatches;
  int outstanding;
  int pixels_sent = 0;
  int src_idle = 14;
  int snk_idle = 74;

  binary_mask_centroid u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  bmc_centroid_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_idle);
  end

  // entered just after a rising edge; returns at the edge of the transfer
  task automatic send_pixel(input logic [7:0] value, input logic [11:0] col,
                            input logic [11:0] row, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {row, col, value};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    pixels_sent++;
  endtask

  task automatic wait_all_centroids();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic send_random_frame();
    int          n_pix;
    int          width;
    int          style;
    int          scatter;
    logic [11:0] x0;
    logic [11:0] y0;
    logic [11:0] col;
    logic [11:0] row;
    logic [7:0]  value;
    n_pix = ($urandom_range(19) == 0) ? $urandom_range(300, 40) : $urandom_range(24, 1);
    width = $urandom_range(64, 1);
    x0 = 12'($urandom);
    y0 = 12'($urandom);
    style = $urandom_range(9);
    scatter = ($urandom_range(3) == 0);
    for (int i = 0; i < n_pix; i++) begin
      case (style)
        6, 7: value = ($urandom_range(99) < 95) ? 8'd255 : 8'd0;
        8: value = ($urandom_range(9) == 0) ? 8'd255 : 8'($urandom);
        9: value = ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(254));
        default: value = ($urandom_range(99) < 60) ? 8'd255 : 8'd0;
      endcase
      if (scatter) begin
        col = 12'($urandom);
        row = 12'($urandom);
      end else begin
        // raster walk, wrapping at the coordinate width
        col = x0 + 12'(i % width);
        row = y0 + 12'(i / width);
      end
      send_pixel(value, col, row, i == n_pix - 1);
    end
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int base;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty single-pixel frame
    send_pixel(8'd0, 12'd0, 12'd0, 1'b1);
    // lone pixel at the far corner
    send_pixel(8'd255, 12'hFFF, 12'hFFF, 1'b1);
    // lone pixel at the origin: zero center but not empty
    send_pixel(8'd255, 12'd0, 12'd0, 1'b1);
    // near-miss values do not count; half fractions
    send_pixel(8'd255, 12'd1, 12'd2, 1'b0);
    send_pixel(8'd255, 12'd2, 12'hFFF, 1'b0);
    send_pixel(8'd254, 12'hFFF, 12'hFFF, 1'b0);
    send_pixel(8'd127, 12'd1, 12'd1, 1'b1);
    // thirds, last pixel counted
    send_pixel(8'd255, 12'd0, 12'd1, 1'b0);
    send_pixel(8'd255, 12'd1, 12'd1, 1'b0);
    send_pixel(8'd255, 12'd1, 12'd0, 1'b1);
    // only the last pixel counts
    send_pixel(8'd128, 12'd2048, 12'd2048, 1'b0);
    send_pixel(8'd1, 12'd5, 12'd5, 1'b0);
    send_pixel(8'd0, 12'd7, 12'd7, 1'b0);
    send_pixel(8'd255, 12'd10, 12'd20, 1'b1);
    // multi-pixel empty frame with alternating bit patterns
    send_pixel(8'hAA, 12'hAAA, 12'h555, 1'b0);
    send_pixel(8'h55, 12'h555, 12'hAAA, 1'b1);
    wait_all_centroids();

    base = pixels_sent;
    for (int phase = 0; phase < 3; phase++) begin
      src_idle = (phase == 0) ? 14 : (phase == 1) ? 74 : 0;
      snk_idle = (phase == 0) ? 74 : (phase == 1) ? 14 : 0;
      while (pixels_sent < base + (phase + 1) * RANDOM_PIXELS / 3)
        send_random_frame();
      // hold the source until every centroid is out
      wait_all_centroids();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
